@@ design/lsc_pkg.sv @@
package lsc_pkg;

  localparam int COORD_BITS       = 24;
  localparam int DEF_HALF_WINDOW  = 5;
  localparam int DEF_MAX_POINTS   = 524288;

  localparam int FRAC_BITS        = 16;
  localparam int QUOT_BITS        = 32;
  localparam int INDEX_BITS       = 19;

  localparam int IN_DATA_W        = 3 * COORD_BITS;
  localparam int IN_USER_W        = 2;
  localparam int OUT_DATA_W       = 56;
  localparam int OUT_PAD_W        = OUT_DATA_W - QUOT_BITS - INDEX_BITS;

  // input tuser bit positions
  localparam int TU_POINT_VALID   = 0;
  localparam int TU_CLOUD_START   = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // x sits in the low bits, as on tdata
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

endpackage

@@ design/lsc_div.sv @@
module lsc_div
  import lsc_pkg::*;
#(
  parameter int NUM_W = 58,
  parameter int DEN_W = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [QUOT_BITS-1:0] quot
);

  localparam int HI_W  = NUM_W - FRAC_BITS;
  localparam int REM_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
  localparam int CNT_W = $clog2(QUOT_BITS);

  logic [REM_W-1:0]     rem;
  logic [QUOT_BITS-1:0] qsh;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;

  logic [REM_W-1:0] rem_init;
  logic [REM_W-1:0] den_ext;
  logic [REM_W-1:0] trial;
  logic             init_sat;
  logic             trial_ge;

  assign rem_init = REM_W'(num[NUM_W-1:FRAC_BITS]);
  assign den_ext  = REM_W'(den);
  // quotient would not fit in 32 bits (also catches a zero divisor)
  assign init_sat = rem_init >= den_ext;
  assign trial    = {rem[REM_W-2:0], qsh[QUOT_BITS-1]};
  assign trial_ge = trial >= den_ext;
  assign quot     = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (init_sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle; dividend low bits shift out
  // of qsh as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      if (init_sat) begin
        qsh <= '1;
      end else begin
        rem <= rem_init;
        qsh <= {num[FRAC_BITS-1:0], {(QUOT_BITS-FRAC_BITS){1'b0}}};
      end
    end else if (busy) begin
      rem <= trial_ge ? (trial - den_ext) : trial;
      qsh <= {qsh[QUOT_BITS-2:0], trial_ge};
    end
  end

endmodule

@@ design/lidar_scan_curvature.sv @@
// Local curvature of a lidar point stream. Points with point_valid low are
// dropped; cloud_start clears the window and the point index before its own
// beat is handled. Once 2*HALF_WINDOW+1 valid points are held, each further
// valid point yields one result for the window centre: the squared norm of
// (sum of neighbours - 2*HALF_WINDOW*centre) over the centre's squared range,
// unsigned Q16.16 saturating at all ones, with zero_range set (and curvature
// all ones) when the centre sits at the origin. Valid points past MAX_POINTS
// in one cloud are ignored. A beat that produces no result leaves tready high.
// A beat that produces a result holds tready low through the stencil pass over
// the window, the squares on the shared squaring multiplier, the one-bit-per-cycle
// divider (cut short when the quotient saturates or the range is zero) and the
// load of the output register, plus any time the previous result still waits
// for m_axis_tready. The result sits in an output register, so the next point
// is taken while it waits for tready.
module lidar_scan_curvature
  import lsc_pkg::*;
#(
  parameter int HALF_WINDOW = DEF_HALF_WINDOW,
  parameter int MAX_POINTS  = DEF_MAX_POINTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // x_coord, y_coord, z_coord
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // point_valid, cloud_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // curvature, center_index, zeros
  output logic [0:0]            m_axis_tuser    // zero_range
);

  localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int IW      = $clog2(WIN_LEN);
  localparam int STW     = (IW > 3) ? IW : 3;
  localparam int FW      = $clog2(WIN_LEN + 1);
  localparam int CW      = $clog2(MAX_POINTS + 1);
  localparam int SW      = COORD_BITS + $clog2(2 * HALF_WINDOW) + 1;
  localparam int NW      = 2 * SW;
  localparam int RW      = 2 * COORD_BITS;
  localparam int SQ_LAST = 7;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_STENCIL = 3'd1;
  localparam logic [2:0] ST_SQUARE  = 3'd2;
  localparam logic [2:0] ST_DIVIDE  = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  function automatic logic signed [SW-1:0] sext(input coord_t v);
    return {{(SW-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  logic [2:0]            state;
  logic [STW-1:0]        step;
  logic [FW-1:0]         fill;
  logic [CW-1:0]         count;
  point_t                window [WIN_LEN];
  logic [INDEX_BITS-1:0] cidx;
  logic signed [SW-1:0]  acc_x, acc_y, acc_z;
  logic [NW-1:0]         prod;
  logic [NW-1:0]         num;
  logic [RW-1:0]         r2;

  logic [QUOT_BITS-1:0]  out_curv;
  logic [INDEX_BITS-1:0] out_idx;
  logic                  out_zero;

  logic                  in_acc;
  point_t                in_pt;
  logic                  pt_valid;
  logic                  pt_start;
  logic [FW-1:0]         fill_base;
  logic [FW-1:0]         fill_inc;
  logic [CW-1:0]         count_base;
  logic [CW-1:0]         cdiff;
  logic                  take;
  logic                  fire;
  point_t                win_rd;
  point_t                ctr;
  logic signed [SW-1:0]  sq_op;
  logic [SW-2:0]         sq_mag;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_BITS-1:0]  div_quot;
  logic                  out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_pt         = point_t'(s_axis_tdata);
  assign pt_valid      = s_axis_tuser[TU_POINT_VALID];
  assign pt_start      = s_axis_tuser[TU_CLOUD_START];

  assign fill_base  = pt_start ? '0 : fill;
  assign count_base = pt_start ? '0 : count;
  assign fill_inc   = fill_base + FW'(fill_base < FW'(WIN_LEN));
  assign take       = pt_valid && (count_base < CW'(MAX_POINTS));
  assign fire       = in_acc && take && (fill_inc == FW'(WIN_LEN));
  assign cdiff      = count_base - CW'(HALF_WINDOW);

  assign win_rd = window[step[IW-1:0]];
  assign ctr    = window[HALF_WINDOW];

  always_comb begin
    case (step)
      STW'(0): sq_op = acc_x;
      STW'(1): sq_op = acc_y;
      STW'(2): sq_op = acc_z;
      STW'(3): sq_op = sext(ctr.x);
      STW'(4): sq_op = sext(ctr.y);
      STW'(5): sq_op = sext(ctr.z);
      default: sq_op = '0;
    endcase
  end

  // magnitude fits one bit less: the stencil never reaches the negative limit
  assign sq_mag    = sq_op[SW-1] ? (SW-1)'(-sq_op) : sq_op[SW-2:0];
  assign div_start = (state == ST_SQUARE) && (step == STW'(SQ_LAST));
  assign out_load  = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      fill          <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            fill  <= take ? fill_inc : fill_base;
            count <= take ? (count_base + 1'b1) : count_base;
            if (fire) begin
              state <= ST_STENCIL;
              step  <= '0;
            end
          end
        end
        ST_STENCIL: begin
          if (step == STW'(WIN_LEN - 1)) begin
            state <= ST_SQUARE;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SQUARE: begin
          if (step == STW'(SQ_LAST)) begin
            state <= ST_DIVIDE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && take) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[WIN_LEN-1] <= in_pt;
    end

    if (fire) begin
      cidx  <= INDEX_BITS'(cdiff);
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
      num   <= '0;
      r2    <= '0;
    end

    // sum of (neighbour - centre); the centre term itself adds zero
    if (state == ST_STENCIL) begin
      acc_x <= acc_x + (sext(win_rd.x) - sext(ctr.x));
      acc_y <= acc_y + (sext(win_rd.y) - sext(ctr.y));
      acc_z <= acc_z + (sext(win_rd.z) - sext(ctr.z));
    end

    // product registered one step, accumulated the next
    if (state == ST_SQUARE) begin
      prod <= NW'(sq_mag) * NW'(sq_mag);
      if (step >= STW'(1) && step <= STW'(3)) begin
        num <= num + prod;
      end else if (step >= STW'(4) && step <= STW'(6)) begin
        r2 <= r2 + prod[RW-1:0];
      end
    end

    if (out_load) begin
      out_curv <= div_quot;
      out_idx  <= cidx;
      out_zero <= (r2 == '0);
    end
  end

  lsc_div #(
    .NUM_W (NW),
    .DEN_W (RW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (r2),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_idx, out_curv};
  assign m_axis_tuser = out_zero;

endmodule

@@ design/lsc_checker.sv @@
module lsc_checker
  import lsc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // zero range forces saturated curvature
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[QUOT_BITS-1:0] == '1)
    else $error("zero_range without saturated curvature");

  // a new result only comes out of the compute phase, when input is held off
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a compute phase");

  // a dropped point never starts a computation
  a_drop_free: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[TU_POINT_VALID] |=> s_axis_tready)
    else $error("invalid point stalled the input");

  // a dropped point does not produce a result
  a_in_seen: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[TU_POINT_VALID] |=>
      !$rose(m_axis_tvalid))
    else $error("result produced by a dropped point");

endmodule

bind lidar_scan_curvature lsc_checker u_lsc_checker (.*);
